// ----- rtl/lobm_pkg.sv -----
package lobm_pkg;

   // fixed field widths
   localparam int CMD_BITS     = 2;
   localparam int ID_BITS      = 32;
   localparam int ARRIVAL_BITS = 32;
   localparam int FILL_BITS    = 9;
   localparam int STATUS_BITS  = 3;

   // request commands
   localparam logic [CMD_BITS-1:0] CMD_NEW    = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_CANCEL = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_DELETE = 2'd2;

   // response status codes
   localparam logic [STATUS_BITS-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_BITS-1:0] STAT_NOT_FOUND = 3'd1;
   localparam logic [STATUS_BITS-1:0] STAT_FULL      = 3'd2;
   localparam logic [STATUS_BITS-1:0] STAT_IGNORED   = 3'd3;
   localparam logic [STATUS_BITS-1:0] STAT_REMOVED   = 3'd4;

   // pending edit applied to one slot as it passes the head of the ring
   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_SUB    = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_INSERT = 2'd3
   } act_kind_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MATCH  = 6'b000010,
      ST_SEARCH = 6'b000100,
      ST_DECIDE = 6'b001000,
      ST_OUTPUT = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

endpackage

// ----- rtl/lobm_cell.sv -----
module lobm_cell import lobm_pkg::*; #(
   parameter int PRICE_BITS = 32,
   parameter int QTY_BITS   = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    shift,
   input  logic                    in_valid,
   input  logic                    in_side,
   input  logic [PRICE_BITS-1:0]   in_price,
   input  logic [QTY_BITS-1:0]     in_shares,
   input  logic [ID_BITS-1:0]      in_ident,
   input  logic [ARRIVAL_BITS-1:0] in_arrival,
   output logic                    out_valid,
   output logic                    out_side,
   output logic [PRICE_BITS-1:0]   out_price,
   output logic [QTY_BITS-1:0]     out_shares,
   output logic [ID_BITS-1:0]      out_ident,
   output logic [ARRIVAL_BITS-1:0] out_arrival
);

   logic                    valid_ff;
   logic                    side_ff;
   logic [PRICE_BITS-1:0]   price_ff;
   logic [QTY_BITS-1:0]     shares_ff;
   logic [ID_BITS-1:0]      ident_ff;
   logic [ARRIVAL_BITS-1:0] arrival_ff;

   // occupancy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= in_valid;
      end
   end

   // order payload, taken from the neighbor while the ring turns
   always_ff @(posedge clock) begin
      if (shift) begin
         side_ff    <= in_side;
         price_ff   <= in_price;
         shares_ff  <= in_shares;
         ident_ff   <= in_ident;
         arrival_ff <= in_arrival;
      end
   end

   assign out_valid   = valid_ff;
   assign out_side    = side_ff;
   assign out_price   = price_ff;
   assign out_shares  = shares_ff;
   assign out_ident   = ident_ff;
   assign out_arrival = arrival_ff;

endmodule

// ----- rtl/limit_order_book_matcher.sv -----
// Two-sided limit order book with price-time priority.
// Request channel (req_*): tuser carries the command; tdata carries side, limit
// price, quantity and order id. Response channel (rsp_*): one response per
// request, tuser carries the status; tdata carries executed and rested shares,
// fill count and best bid / best ask after the request.
// The book is a ring of MAX_ORDERS cells. Every pass turns the ring once so
// each slot goes by the head, where the pending edit is applied and the slot
// is compared against the running best.
// Steps per request: an ignored command or zero-size order goes straight to
// the output pass; a cancel or delete runs a search pass and a decision first;
// a new order runs a match pass and a decision for each fill, plus a last pair
// when the order is not filled in full, before the output pass.
// One request is worked on at a time; the next one is taken while a finished
// response still waits in the output register. If the receiver stalls, the
// response holds and the block stops after the following request.
// Reset empties the book and clears the arrival counter; it is ready at once.
module limit_order_book_matcher import lobm_pkg::*; #(
   parameter int MAX_ORDERS = 256,
   parameter int PRICE_BITS = 32,
   parameter int QTY_BITS   = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // side, limit_price, quantity, order_id
   input  logic [((1+PRICE_BITS+QTY_BITS+ID_BITS+7)/8)*8-1:0] req_tdata,
   // command
   input  logic [CMD_BITS-1:0]  req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // executed_qty, rested_qty, fill_count, best_bid_valid, best_bid_price,
   // best_ask_valid, best_ask_price
   output logic [((2*QTY_BITS+FILL_BITS+2+2*PRICE_BITS+7)/8)*8-1:0] rsp_tdata,
   // status
   output logic [STATUS_BITS-1:0] rsp_tuser
);

   localparam int IDX_W   = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
   localparam int RSP_RAW = 2*QTY_BITS+FILL_BITS+2+2*PRICE_BITS;
   localparam int RSP_W   = ((RSP_RAW+7)/8)*8;
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(MAX_ORDERS-1);

   // ring of cells
   logic                    c_valid   [MAX_ORDERS];
   logic                    c_side    [MAX_ORDERS];
   logic [PRICE_BITS-1:0]   c_price   [MAX_ORDERS];
   logic [QTY_BITS-1:0]     c_shares  [MAX_ORDERS];
   logic [ID_BITS-1:0]      c_ident   [MAX_ORDERS];
   logic [ARRIVAL_BITS-1:0] c_arrival [MAX_ORDERS];

   logic                    h_valid;
   logic                    h_side;
   logic [PRICE_BITS-1:0]   h_price;
   logic [QTY_BITS-1:0]     h_shares;
   logic [ID_BITS-1:0]      h_ident;
   logic [ARRIVAL_BITS-1:0] h_arrival;
   logic                    shift;

   for (genvar i = 0; i < MAX_ORDERS; i++) begin : g_ring
      if (i == MAX_ORDERS-1) begin : g_tail
         lobm_cell #(.PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS)) u_cell (
            .clock(clock), .reset(reset), .shift(shift),
            .in_valid(h_valid), .in_side(h_side), .in_price(h_price),
            .in_shares(h_shares), .in_ident(h_ident), .in_arrival(h_arrival),
            .out_valid(c_valid[i]), .out_side(c_side[i]), .out_price(c_price[i]),
            .out_shares(c_shares[i]), .out_ident(c_ident[i]),
            .out_arrival(c_arrival[i]));
      end else begin : g_body
         lobm_cell #(.PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS)) u_cell (
            .clock(clock), .reset(reset), .shift(shift),
            .in_valid(c_valid[i+1]), .in_side(c_side[i+1]), .in_price(c_price[i+1]),
            .in_shares(c_shares[i+1]), .in_ident(c_ident[i+1]),
            .in_arrival(c_arrival[i+1]),
            .out_valid(c_valid[i]), .out_side(c_side[i]), .out_price(c_price[i]),
            .out_shares(c_shares[i]), .out_ident(c_ident[i]),
            .out_arrival(c_arrival[i]));
      end
   end

   // control and request registers
   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic [CMD_BITS-1:0]     cmd_ff, cmd_in;
   logic                    side_ff, side_in;
   logic [PRICE_BITS-1:0]   price_ff, price_in;
   logic [QTY_BITS-1:0]     rem_ff, rem_in;
   logic [ID_BITS-1:0]      id_ff, id_in;
   logic [QTY_BITS-1:0]     exec_ff, exec_in;
   logic [QTY_BITS-1:0]     rested_ff, rested_in;
   logic [FILL_BITS-1:0]    fills_ff, fills_in;
   logic [STATUS_BITS-1:0]  status_ff, status_in;
   act_kind_type            act_kind_ff, act_kind_in;
   logic [IDX_W-1:0]        act_idx_ff, act_idx_in;
   logic [QTY_BITS-1:0]     act_amt_ff, act_amt_in;
   logic [ARRIVAL_BITS-1:0] counter_ff, counter_in;

   // running results of a pass
   logic                    best_valid_ff, best_valid_in;
   logic [PRICE_BITS-1:0]   best_price_ff, best_price_in;
   logic [ARRIVAL_BITS-1:0] best_arr_ff, best_arr_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic [QTY_BITS-1:0]     best_shares_ff, best_shares_in;
   logic                    free_valid_ff, free_valid_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic                    bid_valid_ff, bid_valid_in;
   logic [PRICE_BITS-1:0]   bid_price_ff, bid_price_in;
   logic                    ask_valid_ff, ask_valid_in;
   logic [PRICE_BITS-1:0]   ask_price_ff, ask_price_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]        rsp_data_ff, rsp_data_in;
   logic [STATUS_BITS-1:0]  rsp_user_ff, rsp_user_in;

   logic                    accept;
   logic                    last_pos;
   logic                    first_pos;
   logic                    act_hit;
   logic                    bv_eff;
   logic                    cand;
   logic                    better;
   logic [ARRIVAL_BITS-1:0] age_c;
   logic [ARRIVAL_BITS-1:0] age_b;
   logic                    crosses;
   logic [QTY_BITS-1:0]     fill;
   logic                    load_rsp;
   logic [RSP_W-1:0]        rsp_pack;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign shift      = (state_ff == ST_MATCH) || (state_ff == ST_SEARCH) ||
                       (state_ff == ST_OUTPUT);
   assign last_pos   = (pos_ff == LAST_POS);
   assign first_pos  = (pos_ff == '0);
   assign act_hit    = (act_kind_ff != ACT_NONE) && (pos_ff == act_idx_ff);

   // pending edit on the slot at the head of the ring
   always_comb begin
      h_valid   = c_valid[0];
      h_side    = c_side[0];
      h_price   = c_price[0];
      h_shares  = c_shares[0];
      h_ident   = c_ident[0];
      h_arrival = c_arrival[0];
      if (act_hit) begin
         case (act_kind_ff)
            ACT_SUB: begin
               h_shares = c_shares[0] - act_amt_ff;
            end
            ACT_REMOVE: begin
               h_valid = 1'b0;
            end
            ACT_INSERT: begin
               h_valid   = 1'b1;
               h_side    = side_ff;
               h_price   = price_ff;
               h_shares  = rem_ff;
               h_ident   = id_ff;
               h_arrival = counter_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // best opposite order by price, then age
   assign bv_eff = best_valid_ff && !first_pos;
   assign cand   = h_valid && (h_side != side_ff);
   assign age_c  = counter_ff - h_arrival;
   assign age_b  = counter_ff - best_arr_ff;
   always_comb begin
      if (h_price != best_price_ff) begin
         better = side_ff ? (h_price > best_price_ff) : (h_price < best_price_ff);
      end else begin
         better = (age_c > age_b);
      end
   end

   // decision on the best order found
   assign crosses = best_valid_ff && (side_ff ? (best_price_ff >= price_ff)
                                              : (best_price_ff <= price_ff));
   assign fill    = (rem_ff < best_shares_ff) ? rem_ff : best_shares_ff;

   assign load_rsp = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_tready);

   // response packing
   always_comb begin
      rsp_pack = '0;
      rsp_pack[QTY_BITS-1:0]                   = exec_ff;
      rsp_pack[2*QTY_BITS-1:QTY_BITS]          = rested_ff;
      rsp_pack[2*QTY_BITS+FILL_BITS-1:2*QTY_BITS] = fills_ff;
      rsp_pack[2*QTY_BITS+FILL_BITS]           = bid_valid_ff;
      rsp_pack[2*QTY_BITS+FILL_BITS+1 +: PRICE_BITS] =
         bid_valid_ff ? bid_price_ff : '0;
      rsp_pack[2*QTY_BITS+FILL_BITS+1+PRICE_BITS] = ask_valid_ff;
      rsp_pack[2*QTY_BITS+FILL_BITS+2+PRICE_BITS +: PRICE_BITS] =
         ask_valid_ff ? ask_price_ff : '0;
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      cmd_in         = cmd_ff;
      side_in        = side_ff;
      price_in       = price_ff;
      rem_in         = rem_ff;
      id_in          = id_ff;
      exec_in        = exec_ff;
      rested_in      = rested_ff;
      fills_in       = fills_ff;
      status_in      = status_ff;
      act_kind_in    = act_kind_ff;
      act_idx_in     = act_idx_ff;
      act_amt_in     = act_amt_ff;
      counter_in     = counter_ff;
      best_valid_in  = best_valid_ff;
      best_price_in  = best_price_ff;
      best_arr_in    = best_arr_ff;
      best_idx_in    = best_idx_ff;
      best_shares_in = best_shares_ff;
      free_valid_in  = free_valid_ff;
      free_idx_in    = free_idx_ff;
      bid_valid_in   = bid_valid_ff;
      bid_price_in   = bid_price_ff;
      ask_valid_in   = ask_valid_ff;
      ask_price_in   = ask_price_ff;
      rsp_valid_in   = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;

      if (shift) begin
         pos_in = last_pos ? '0 : pos_ff + IDX_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in      = req_tuser;
               side_in     = req_tdata[0];
               price_in    = req_tdata[PRICE_BITS:1];
               rem_in      = req_tdata[PRICE_BITS+QTY_BITS:PRICE_BITS+1];
               id_in       = req_tdata[PRICE_BITS+QTY_BITS+ID_BITS:PRICE_BITS+QTY_BITS+1];
               exec_in     = '0;
               rested_in   = '0;
               fills_in    = '0;
               status_in   = STAT_OK;
               act_kind_in = ACT_NONE;
               pos_in      = '0;
               if (req_tuser == CMD_NEW) begin
                  state_in = (req_tdata[PRICE_BITS+QTY_BITS:PRICE_BITS+1] != '0)
                             ? ST_MATCH : ST_OUTPUT;
               end else if (req_tuser == CMD_CANCEL || req_tuser == CMD_DELETE) begin
                  state_in = ST_SEARCH;
               end else begin
                  status_in = STAT_IGNORED;
                  state_in  = ST_OUTPUT;
               end
            end
         end
         ST_MATCH: begin
            // best opposite order and lowest free slot
            best_valid_in = bv_eff || cand;
            if (cand && (!bv_eff || better)) begin
               best_price_in  = h_price;
               best_arr_in    = h_arrival;
               best_idx_in    = pos_ff;
               best_shares_in = h_shares;
            end
            free_valid_in = (free_valid_ff && !first_pos) || !h_valid;
            if (!h_valid && !(free_valid_ff && !first_pos)) begin
               free_idx_in = pos_ff;
            end
            if (last_pos) begin
               state_in = ST_DECIDE;
            end
         end
         ST_SEARCH: begin
            // lowest slot holding the id
            best_valid_in = bv_eff || (h_valid && h_ident == id_ff);
            if (h_valid && h_ident == id_ff && !bv_eff) begin
               best_idx_in    = pos_ff;
               best_shares_in = h_shares;
            end
            if (last_pos) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            act_kind_in = ACT_NONE;
            state_in    = ST_OUTPUT;
            if (cmd_ff == CMD_NEW) begin
               if (crosses) begin
                  act_kind_in = (fill == best_shares_ff) ? ACT_REMOVE : ACT_SUB;
                  act_idx_in  = best_idx_ff;
                  act_amt_in  = fill;
                  rem_in      = rem_ff - fill;
                  exec_in     = exec_ff + fill;
                  fills_in    = fills_ff + FILL_BITS'(1);
                  if (rem_ff != fill) begin
                     state_in = ST_MATCH;
                  end
               end else if (free_valid_ff) begin
                  act_kind_in = ACT_INSERT;
                  act_idx_in  = free_idx_ff;
                  rested_in   = rem_ff;
               end else begin
                  status_in = STAT_FULL;
               end
            end else if (!best_valid_ff) begin
               status_in = STAT_NOT_FOUND;
            end else if (cmd_ff == CMD_DELETE || rem_ff >= best_shares_ff) begin
               act_kind_in = ACT_REMOVE;
               act_idx_in  = best_idx_ff;
               status_in   = STAT_REMOVED;
            end else begin
               act_kind_in = ACT_SUB;
               act_idx_in  = best_idx_ff;
               act_amt_in  = rem_ff;
            end
         end
         ST_OUTPUT: begin
            // best bid and best ask after the edit
            bid_valid_in = (bid_valid_ff && !first_pos) || (h_valid && !h_side);
            if (h_valid && !h_side &&
                (!(bid_valid_ff && !first_pos) || h_price > bid_price_ff)) begin
               bid_price_in = h_price;
            end
            ask_valid_in = (ask_valid_ff && !first_pos) || (h_valid && h_side);
            if (h_valid && h_side &&
                (!(ask_valid_ff && !first_pos) || h_price < ask_price_ff)) begin
               ask_price_in = h_price;
            end
            if (last_pos) begin
               if (act_kind_ff == ACT_INSERT) begin
                  counter_in = counter_ff + ARRIVAL_BITS'(1);
               end
               act_kind_in = ACT_NONE;
               state_in    = ST_RESP;
            end
         end
         ST_RESP: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rsp_pack;
               rsp_user_in  = status_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         act_kind_ff  <= ACT_NONE;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         act_kind_ff  <= act_kind_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      side_ff        <= side_in;
      price_ff       <= price_in;
      rem_ff         <= rem_in;
      id_ff          <= id_in;
      exec_ff        <= exec_in;
      rested_ff      <= rested_in;
      fills_ff       <= fills_in;
      status_ff      <= status_in;
      act_idx_ff     <= act_idx_in;
      act_amt_ff     <= act_amt_in;
      best_valid_ff  <= best_valid_in;
      best_price_ff  <= best_price_in;
      best_arr_ff    <= best_arr_in;
      best_idx_ff    <= best_idx_in;
      best_shares_ff <= best_shares_in;
      free_valid_ff  <= free_valid_in;
      free_idx_ff    <= free_idx_in;
      bid_valid_ff   <= bid_valid_in;
      bid_price_ff   <= bid_price_in;
      ask_valid_ff   <= ask_valid_in;
      ask_price_ff   <= ask_price_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_user_ff    <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- tb/lobm_checker.sv -----
`timescale 1ns / 100ps

module lobm_checker import lobm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // side, limit_price, quantity, order_id
   input  logic [95:0]  req_tdata,
   // command
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // executed_qty, rested_qty, fill_count, best_bid_valid, best_bid_price,
   // best_ask_valid, best_ask_price
   input  logic [127:0] rsp_tdata,
   // status
   input  logic [2:0]   rsp_tuser,
   output int           fail_count,
   output int           pending
);

   localparam int DEPTH = 256;

   typedef struct packed {
      logic [23:0] executed;
      logic [23:0] rested;
      logic [8:0]  fills;
      logic [2:0]  status;
      logic        bid_ok;
      logic [31:0] bid_px;
      logic        ask_ok;
      logic [31:0] ask_px;
   } book_rsp_type;

   // shadow copy of the book
   logic        live [DEPTH];
   logic        sd   [DEPTH];
   logic [31:0] px   [DEPTH];
   logic [23:0] shr  [DEPTH];
   logic [31:0] oid  [DEPTH];
   logic [31:0] arr  [DEPTH];
   logic [31:0] arrival_count;

   book_rsp_type expected_book_rsp [$];

   assign pending = expected_book_rsp.size();

   // top of one side: 0 bids (highest), 1 asks (lowest); oldest wins on a tie
   function automatic int top_of_side(logic s);
      int best;
      logic [31:0] age_i, age_b;
      best = -1;
      for (int i = 0; i < DEPTH; i++) begin
         if (!live[i] || sd[i] != s) continue;
         if (best < 0) begin
            best = i;
            continue;
         end
         if (px[i] != px[best]) begin
            if (s ? (px[i] < px[best]) : (px[i] > px[best])) best = i;
         end else begin
            age_i = arrival_count - arr[i];
            age_b = arrival_count - arr[best];
            if (age_i > age_b) best = i;
         end
      end
      return best;
   endfunction

   function automatic int slot_of_id(logic [31:0] id);
      for (int i = 0; i < DEPTH; i++)
         if (live[i] && oid[i] == id) return i;
      return -1;
   endfunction

   // apply one request to the shadow book and return the response it yields
   function automatic book_rsp_type match_order(logic [1:0] cmd, logic side,
         logic [31:0] price, logic [23:0] qty, logic [31:0] id);
      book_rsp_type r;
      logic [23:0] left, fill;
      int b, f, k;
      r = '0;
      if (cmd == CMD_NEW) begin
         left = qty;
         while (left > 0) begin
            b = top_of_side(!side);
            if (b < 0) break;
            if (side == 1'b0 ? (px[b] > price) : (px[b] < price)) break;
            fill = (left < shr[b]) ? left : shr[b];
            left -= fill;
            r.executed += fill;
            r.fills++;
            if (fill == shr[b]) live[b] = 1'b0;
            else shr[b] -= fill;
         end
         if (left > 0) begin
            f = -1;
            for (k = 0; k < DEPTH; k++)
               if (!live[k]) begin
                  f = k;
                  break;
               end
            if (f < 0) begin
               r.status = STAT_FULL;
            end else begin
               live[f] = 1'b1;
               sd[f] = side;
               px[f] = price;
               shr[f] = left;
               oid[f] = id;
               arr[f] = arrival_count;
               arrival_count++;
               r.rested = left;
            end
         end
      end else if (cmd == CMD_CANCEL || cmd == CMD_DELETE) begin
         k = slot_of_id(id);
         if (k < 0) begin
            r.status = STAT_NOT_FOUND;
         end else if (cmd == CMD_DELETE || qty >= shr[k]) begin
            live[k] = 1'b0;
            r.status = STAT_REMOVED;
         end else begin
            shr[k] -= qty;
            r.status = STAT_OK;
         end
      end else begin
         r.status = STAT_IGNORED;
      end
      b = top_of_side(1'b0);
      f = top_of_side(1'b1);
      r.bid_ok = (b >= 0);
      r.bid_px = (b >= 0) ? px[b] : '0;
      r.ask_ok = (f >= 0);
      r.ask_px = (f >= 0) ? px[f] : '0;
      return r;
   endfunction

   task automatic report(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   book_rsp_type got, want;

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) live[i] = 1'b0;
         arrival_count = '0;
         expected_book_rsp.delete();
      end else begin
         // response side: compare with the oldest outstanding request
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[23:0], rsp_tdata[47:24], rsp_tdata[56:48], rsp_tuser,
                   rsp_tdata[57], rsp_tdata[89:58], rsp_tdata[90], rsp_tdata[122:91]};
            if (expected_book_rsp.size() == 0) begin
               $display("%0t: response with no request outstanding", $time);
               fail_count++;
            end else begin
               want = expected_book_rsp.pop_front();
               report("executed_qty", want.executed, got.executed);
               report("rested_qty", want.rested, got.rested);
               report("fill_count", want.fills, got.fills);
               report("status", want.status, got.status);
               report("best_bid_valid", want.bid_ok, got.bid_ok);
               report("best_bid_price", want.bid_px, got.bid_px);
               report("best_ask_valid", want.ask_ok, got.ask_ok);
               report("best_ask_price", want.ask_px, got.ask_px);
            end
         end
         // request side
         if (req_tvalid && req_tready)
            expected_book_rsp.push_back(match_order(req_tuser, req_tdata[0],
               req_tdata[32:1], req_tdata[56:33], req_tdata[88:57]));
      end
   end

   initial fail_count = 0;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import lobm_pkg::*;

   localparam int RANDOM_ORDERS = 1200;
   localparam int STALL_LIMIT   = 300000;
   localparam logic [1:0] CMD_OTHER = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   int           fail_count, pending;
   logic         calm = 1'b0;
   int           quiet_cycles = 0;
   logic [31:0]  issued_ids [$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   limit_order_book_matcher DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   lobm_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .fail_count(fail_count), .pending(pending)
   );

   // receiver stalls about a quarter of the time, never during the calm stretch
   always @(posedge clock)
      rsp_tready <= calm || ($urandom_range(0, 99) >= 24);

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("limit_order_book_matcher: mismatch");
         $finish;
      end
   end

   // one request: optional idle gap, then hold valid until accepted
   task automatic send_request(logic [1:0] cmd, logic side, logic [31:0] price,
         logic [23:0] qty, logic [31:0] id);
      int gap;
      if (!calm && $urandom_range(0, 99) < 24) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'b0, id, qty, price, side};
      if (cmd == CMD_NEW && issued_ids.size() < 512) issued_ids.push_back(id);
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [31:0] known_id();
      if (issued_ids.size() == 0 || $urandom_range(0, 9) == 0) return $urandom;
      return issued_ids[$urandom_range(0, issued_ids.size() - 1)];
   endfunction

   task automatic random_request(int n);
      logic [1:0]  cmd;
      logic        side;
      logic [31:0] price;
      logic [23:0] qty;
      int          pick;
      pick  = $urandom_range(0, 99);
      side  = 1'($urandom_range(0, 1));
      price = 32'd1000 + $urandom_range(0, 40) - 20;
      qty   = 24'($urandom_range(1, 60));
      if (n >= 400 && n < 700) begin
         // build up a deep bid side until the book runs full
         cmd   = (pick < 90) ? CMD_NEW : CMD_CANCEL;
         side  = 1'b0;
         price = 32'd900 + $urandom_range(0, 50);
         qty   = 24'($urandom_range(1, 20));
      end else if (n == 700) begin
         // sweep the whole bid side
         cmd = CMD_NEW; side = 1'b1; price = '0; qty = 24'hFFFFFF;
      end else if (pick < 60) cmd = CMD_NEW;
      else if (pick < 80) begin
         cmd = CMD_CANCEL;
         qty = 24'($urandom_range(0, 30));
      end else if (pick < 92) cmd = CMD_DELETE;
      else cmd = CMD_OTHER;
      if ($urandom_range(0, 19) == 0) price = $urandom;
      if ($urandom_range(0, 19) == 0) qty = 24'($urandom);
      send_request(cmd, side, price, qty,
                   (cmd == CMD_NEW || cmd == CMD_OTHER) ? $urandom : known_id());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: ignored command, zero size, time priority, cancels, extremes
      send_request(CMD_OTHER, 1'b1, '1, '1, '1);
      send_request(CMD_NEW, 1'b0, 32'd100, 24'd0, 32'd1);
      send_request(CMD_NEW, 1'b0, 32'd100, 24'd10, 32'd1);
      send_request(CMD_NEW, 1'b0, 32'd100, 24'd5, 32'd2);
      send_request(CMD_NEW, 1'b1, 32'd0, 24'd12, 32'd3);
      send_request(CMD_CANCEL, 1'b0, 32'd0, 24'd0, 32'd2);
      send_request(CMD_CANCEL, 1'b0, 32'd0, 24'd1, 32'd2);
      send_request(CMD_CANCEL, 1'b0, 32'd0, '1, 32'd2);
      send_request(CMD_CANCEL, 1'b0, 32'd0, 24'd1, 32'd99);
      send_request(CMD_DELETE, 1'b0, 32'd0, 24'd0, 32'd99);
      send_request(CMD_NEW, 1'b1, '1, '1, '1);
      send_request(CMD_NEW, 1'b0, '1, 24'd7, 32'd4);
      send_request(CMD_DELETE, 1'b0, 32'd0, 24'd0, '1);
      send_request(CMD_NEW, 1'b0, '1, '1, 32'd5);
      send_request(CMD_NEW, 1'b1, 32'd0, '1, 32'd6);
      // duplicate ids act on the lowest slot first
      send_request(CMD_NEW, 1'b0, 32'd50, 24'd3, 32'd7);
      send_request(CMD_NEW, 1'b0, 32'd60, 24'd3, 32'd7);
      send_request(CMD_CANCEL, 1'b0, 32'd0, 24'd1, 32'd7);
      send_request(CMD_DELETE, 1'b0, 32'd0, 24'd0, 32'd7);
      send_request(CMD_DELETE, 1'b0, 32'd0, 24'd0, 32'd7);
      send_request(CMD_DELETE, 1'b0, 32'd0, 24'd0, 32'd7);

      for (int n = 0; n < RANDOM_ORDERS; n++) begin
         calm <= (n >= 200 && n < 400);
         random_request(n);
      end
      req_tvalid <= 1'b0;
      calm <= 1'b1;

      while (pending != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (fail_count == 0)
         $display("limit_order_book_matcher: match");
      else
         $display("limit_order_book_matcher: mismatch");
      $finish;
   end

endmodule
